// ===== sv/wctc_pkg.sv =====
// Shared constants and codes for the wall column texture coordinate pipeline.
// No dependencies; used by the top level and its port checker.
`timescale 1ns / 1ps

package wctc_pkg;

  // Default screen height, in rows.
  localparam int SCREEN_HEIGHT_DEF = 512;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_TEX_WIDTH       = 2'd0,
    CFG_TEX_HEIGHT_LOG2 = 2'd1,
    CFG_TEXTURE_PRESENT = 2'd2
  } cfg_idx_e;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Configuration reset values.
  localparam logic [10:0] TEX_WIDTH_RST       = 11'd64;
  localparam logic [3:0]  TEX_HEIGHT_LOG2_RST = 4'd6;
  localparam logic [3:0]  TEXTURE_PRESENT_RST = 4'hF;

  // Texture ids.
  localparam logic [1:0] TEX_EAST  = 2'd0;
  localparam logic [1:0] TEX_WEST  = 2'd1;
  localparam logic [1:0] TEX_SOUTH = 2'd2;
  localparam logic [1:0] TEX_NORTH = 2'd3;

  // Texture row: largest height log2, and the long division that forms it.
  localparam logic [3:0] TEX_LOG2_MAX = 4'd10;
  localparam int FRAC_BITS       = 10;
  localparam int MAG_W           = 16;                 // |row offset| bits
  localparam int DVD_W           = MAG_W + FRAC_BITS;  // dividend bits
  localparam int DIV_STEPS       = DVD_W;
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

endpackage

// ===== sv/wall_column_texture_coords.sv =====
// Raycaster wall column texture coordinates: texture choice, texel column and row per pixel.
// Depends on wctc_pkg.
`timescale 1ns / 1ps

// Takes one wall pixel per clock while in_ready_o is high and returns one result per pixel,
// in order. The pipeline depth is set by the texture row, which needs a restoring
// division of the row offset (scaled by 2^10) by slice_height: 26 divide steps, four per
// pipeline stage. The texture column path (multiply, fractional scale, mirror) runs in
// parallel in the first stages. Valid bits ride with each stage and empty stages fill while
// the output is held, so a stalled result does not block new input until the pipeline is
// full. Configuration writes are accepted every cycle and must only be issued while no item
// is in flight.
module wall_column_texture_coords #(
  parameter int SCREEN_HEIGHT = wctc_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wctc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wctc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [9:0]                      column_x_i,
  input  logic [8:0]                      row_y_i,
  input  logic                            hit_side_i,
  input  logic signed [17:0]              dir_x_i,
  input  logic signed [17:0]              dir_y_i,
  input  logic [23:0]                     perp_dist_i,
  input  logic [21:0]                     player_x_i,
  input  logic [21:0]                     player_y_i,
  input  logic [8:0]                      span_start_i,
  input  logic [8:0]                      span_end_i,
  input  logic [15:0]                     slice_height_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [9:0]                      pixel_x_o,
  output logic [8:0]                      pixel_y_o,
  output logic                            in_span_o,
  output logic                            flat_white_o,
  output logic [1:0]                      texture_id_o,
  output logic [9:0]                      texel_x_o,
  output logic [9:0]                      texel_y_o
);

  localparam int NSTG = wctc_pkg::DIV_STAGES + 2;
  localparam int SPS  = wctc_pkg::STEPS_PER_STAGE;
  localparam int MW   = wctc_pkg::MAG_W;
  localparam int DW   = wctc_pkg::DVD_W;
  localparam int FB   = wctc_pkg::FRAC_BITS;
  localparam logic signed [MW+1:0] HALF_H = (MW+2)'(SCREEN_HEIGHT / 2);

  typedef struct packed {
    logic [9:0]    col;
    logic [8:0]    row;
    logic          in_span;
    logic          flat_white;
    logic [1:0]    id;
    logic          mirror;
    logic [15:0]   pos_lo;    // low player bits that land in the Q.32 fraction
    logic [31:0]   prod;      // low 32 bits of perp_dist * dir
    logic [31:0]   frac;
    logic [10:0]   tx_raw;
    logic [9:0]    tx;
    logic          neg;       // row offset negative
    logic          lh_zero;
    logic [15:0]   lh;
    logic [DW-1:0] dvd;
    logic [15:0]   rem;
    logic [FB-1:0] quo;       // low quotient bits only
    logic [9:0]    ty;
  } stage_t;

  // ---------------------------------------------------------------- configuration
  logic [10:0] tex_width_q;
  logic [3:0]  tex_lg_q;
  logic [3:0]  present_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q <= wctc_pkg::TEX_WIDTH_RST;
      tex_lg_q    <= wctc_pkg::TEX_HEIGHT_LOG2_RST;
      present_q   <= wctc_pkg::TEXTURE_PRESENT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        wctc_pkg::CFG_TEX_WIDTH:       tex_width_q <= cfg_data_i;
        wctc_pkg::CFG_TEX_HEIGHT_LOG2: tex_lg_q    <= cfg_data_i[3:0];
        wctc_pkg::CFG_TEXTURE_PRESENT: present_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- pipeline control
  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   rdy;
  stage_t          stage_q [NSTG];

  always_comb begin
    rdy[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 0
  logic                  dx_pos, dy_pos, dy_neg;
  logic signed [17:0]    dir_sel;
  logic signed [42:0]    prod_full;
  logic signed [MW+1:0]  row_off;
  logic [1:0]            id0;
  stage_t                s0_d;

  assign dx_pos    = !dir_x_i[17] && (dir_x_i != '0);
  assign dy_pos    = !dir_y_i[17] && (dir_y_i != '0);
  assign dy_neg    = dir_y_i[17];
  assign dir_sel   = hit_side_i ? dir_x_i : dir_y_i;
  assign prod_full = $signed({1'b0, perp_dist_i}) * dir_sel;
  assign row_off   = $signed({{(MW-7){1'b0}}, row_y_i}) - HALF_H
                   + $signed({3'b000, slice_height_i[15:1]});
  assign id0       = hit_side_i ? (dy_pos ? wctc_pkg::TEX_SOUTH : wctc_pkg::TEX_NORTH)
                                : (dx_pos ? wctc_pkg::TEX_EAST  : wctc_pkg::TEX_WEST);

  always_comb begin
    logic [MW+1:0] mag;
    s0_d            = '0;
    mag             = row_off[MW+1] ? (MW+2)'(-row_off) : row_off;
    s0_d.col        = column_x_i;
    s0_d.row        = row_y_i;
    s0_d.in_span    = (row_y_i >= span_start_i) && (row_y_i <= span_end_i);
    s0_d.id         = id0;
    s0_d.flat_white = !present_q[id0];
    s0_d.mirror     = hit_side_i ? dy_neg : dx_pos;
    s0_d.pos_lo     = hit_side_i ? player_x_i[15:0] : player_y_i[15:0];
    s0_d.prod       = prod_full[31:0];
    s0_d.neg        = row_off[MW+1];
    s0_d.lh_zero    = (slice_height_i == '0);
    s0_d.lh         = slice_height_i;
    s0_d.dvd        = {mag[MW-1:0], {FB{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      stage_q[0] <= s0_d;
    end
  end

  // ---------------------------------------------------------------- stages 1..NSTG-1
  for (genvar k = 1; k < NSTG; k++) begin : g_stage
    stage_t d;

    always_comb begin
      logic [16:0]   trial;
      logic          qbit;
      logic [42:0]   scaled;
      logic [3:0]    lg;
      logic [3:0]    sh;
      logic [FB-1:0] q_pos;
      logic [FB:0]   c_up;
      logic [FB:0]   rnd;
      logic [FB:0]   c_sh;
      logic [9:0]    mask;
      d = stage_q[k-1];
      // restoring division, a few steps per stage
      if (k <= wctc_pkg::DIV_STAGES) begin
        for (int j = 0; j < SPS; j++) begin
          if ((k - 1) * SPS + j < wctc_pkg::DIV_STEPS) begin
            trial = {d.rem, d.dvd[DW-1]};
            qbit  = (trial >= {1'b0, d.lh});
            d.rem = qbit ? 16'(trial - {1'b0, d.lh}) : trial[15:0];
            d.dvd = {d.dvd[DW-2:0], 1'b0};
            d.quo = {d.quo[FB-2:0], qbit};
          end
        end
      end
      // texture column: Q.32 fraction, scale by width, mirror
      if (k == 1) begin
        d.frac = {d.pos_lo, 16'h0000} + d.prod;
      end
      scaled = 43'(d.frac) * 43'(tex_width_q);
      if (k == 2) begin
        d.tx_raw = scaled[42:32];
      end
      if (k == 3) begin
        d.tx = d.mirror ? 10'(tex_width_q - d.tx_raw - 11'd1) : d.tx_raw[9:0];
      end
      // texture row: quotient scaled by 2^10, shifted down to the texture height.
      // A negative offset rounds its magnitude up, then negates.
      lg    = (tex_lg_q > wctc_pkg::TEX_LOG2_MAX) ? wctc_pkg::TEX_LOG2_MAX : tex_lg_q;
      sh    = wctc_pkg::TEX_LOG2_MAX - lg;
      q_pos = d.quo >> sh;
      c_up  = {1'b0, d.quo} + {{FB{1'b0}}, (d.rem != '0)};
      rnd   = ((FB+1)'(1) << sh) - (FB+1)'(1);
      c_sh  = (c_up + rnd) >> sh;
      mask  = 10'(((FB+1)'(1) << lg) - (FB+1)'(1));
      if (k == NSTG - 1) begin
        if (d.lh_zero) begin
          d.ty = '0;
        end else if (d.neg) begin
          d.ty = 10'(-c_sh[FB-1:0]) & mask;
        end else begin
          d.ty = 10'(q_pos) & mask;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        stage_q[k] <= d;
      end
    end
  end

  // ---------------------------------------------------------------- output
  assign out_valid_o  = v_q[NSTG-1];
  assign pixel_x_o    = stage_q[NSTG-1].col;
  assign pixel_y_o    = stage_q[NSTG-1].row;
  assign in_span_o    = stage_q[NSTG-1].in_span;
  assign flat_white_o = stage_q[NSTG-1].flat_white;
  assign texture_id_o = stage_q[NSTG-1].id;
  assign texel_x_o    = stage_q[NSTG-1].tx;
  assign texel_y_o    = stage_q[NSTG-1].ty;

endmodule

// ===== sv/wctc_checker.sv =====
// Port-level checks for wall_column_texture_coords, attached with a bind.
// Depends on wctc_pkg; tracks the texture height and present registers from the cfg port.
`timescale 1ns / 1ps

module wctc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [wctc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [wctc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [9:0]                      pixel_x_o,
  input logic [8:0]                      pixel_y_o,
  input logic                            in_span_o,
  input logic                            flat_white_o,
  input logic [1:0]                      texture_id_o,
  input logic [9:0]                      texel_x_o,
  input logic [9:0]                      texel_y_o
);

  logic [3:0] lg_q;
  logic [3:0] present_q;
  logic [3:0] lg_sat;
  logic [9:0] ty_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q      <= wctc_pkg::TEX_HEIGHT_LOG2_RST;
      present_q <= wctc_pkg::TEXTURE_PRESENT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        wctc_pkg::CFG_TEX_HEIGHT_LOG2: lg_q      <= cfg_data_i[3:0];
        wctc_pkg::CFG_TEXTURE_PRESENT: present_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign lg_sat  = (lg_q > wctc_pkg::TEX_LOG2_MAX) ? wctc_pkg::TEX_LOG2_MAX : lg_q;
  assign ty_mask = 10'((11'd1 << lg_sat) - 11'd1);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({pixel_x_o, pixel_y_o, in_span_o, flat_white_o, texture_id_o,
               texel_x_o, texel_y_o}))
    else $error("output transfer payload changed while stalled");

  // input back-pressure only when the output side is stalled
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with output free");

  // texture row stays inside the texture height
  a_ty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (texel_y_o & ~ty_mask) == '0)
    else $error("texel_y beyond texture height");

  // flat white follows the present bit of the chosen texture
  a_flat_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> flat_white_o == !present_q[texture_id_o])
    else $error("flat_white disagrees with texture_present");

endmodule

bind wall_column_texture_coords wctc_checker u_wctc_checker (.*);
